/* hdl/mte_pkg.sv */
`timescale 1ns / 1ps

package mte_pkg;

    // Buffer geometry
    localparam int MSG_LEN  = 16;
    localparam int PW       = $clog2(MSG_LEN);
    localparam int LAST_POS = MSG_LEN - 1;
    localparam int SEND_END = MSG_LEN - 2;

    // Key codes
    localparam logic [3:0] KC_MENU  = 4'd10;
    localparam logic [3:0] KC_EXIT  = 4'd11;
    localparam logic [3:0] KC_STAR  = 4'd12;
    localparam logic [3:0] KEY_DIG9 = 4'd9;

    // Result event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_WRITE   = 3'd1;
    localparam logic [2:0] EV_SEND    = 3'd2;
    localparam logic [2:0] EV_REFUSED = 3'd3;
    localparam logic [2:0] EV_EXIT    = 3'd4;

    // Decoded request kinds
    localparam logic [2:0] K_NONE        = 3'd0;
    localparam logic [2:0] K_DIGIT       = 3'd1;
    localparam logic [2:0] K_EXIT        = 3'd2;
    localparam logic [2:0] K_EXIT_HELD   = 3'd3;
    localparam logic [2:0] K_STAR        = 3'd4;
    localparam logic [2:0] K_MENU        = 3'd5;
    localparam logic [2:0] K_MENU_SEND   = 3'd6;
    localparam logic [2:0] K_MENU_REFUSE = 3'd7;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_EMPTY = 7'h00;

    // Multi-tap character strings, element 0 is the first character
    localparam logic [0:2][7:0]  MAP0 = " :0";
    localparam logic [0:16][7:0] MAP1 = ".,-()@/\\+=*#<>[]1";
    localparam logic [0:3][7:0]  MAP2 = "abc2";
    localparam logic [0:3][7:0]  MAP3 = "def3";
    localparam logic [0:3][7:0]  MAP4 = "ghi4";
    localparam logic [0:3][7:0]  MAP5 = "jkl5";
    localparam logic [0:3][7:0]  MAP6 = "mno6";
    localparam logic [0:4][7:0]  MAP7 = "pqrs7";
    localparam logic [0:3][7:0]  MAP8 = "tuv8";
    localparam logic [0:4][7:0]  MAP9 = "wxyz9";

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic rd_cursor;
        logic exec;
        logic star_step;
        logic refuse_emit;
        logic send_rd;
        logic send_emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] kind;
        logic       out_free;
        logic       cursor_zero;
        logic       send_last;
    } t_status;

    function automatic logic [4:0] tap_len(input logic [3:0] key);
        logic [4:0] len;
        case (key)
            4'd0:    len = 5'd3;
            4'd1:    len = 5'd17;
            4'd7:    len = 5'd5;
            4'd9:    len = 5'd5;
            default: len = 5'd4;
        endcase
        return len;
    endfunction

    function automatic logic [6:0] tap_char(input logic [3:0] key, input logic [4:0] idx);
        logic [7:0] ch;
        case (key)
            4'd0:    ch = MAP0[idx[1:0]];
            4'd1:    ch = MAP1[idx];
            4'd2:    ch = MAP2[idx[1:0]];
            4'd3:    ch = MAP3[idx[1:0]];
            4'd4:    ch = MAP4[idx[1:0]];
            4'd5:    ch = MAP5[idx[1:0]];
            4'd6:    ch = MAP6[idx[1:0]];
            4'd7:    ch = MAP7[idx[2:0]];
            4'd8:    ch = MAP8[idx[1:0]];
            4'd9:    ch = MAP9[idx[2:0]];
            default: ch = 8'h00;
        endcase
        return ch[6:0];
    endfunction

endpackage

/* hdl/multi_tap_text_entry.sv */
`timescale 1ns / 1ps

// Multi-tap keypad text entry: one key event is taken at a time and edits a
// 16-character message buffer. The block stalls its input from acceptance
// until the event's last result has been loaded into the output register;
// that register lets the next request be accepted while the final result
// still waits. Single-result events (release, digit, exit, plain menu) pass
// through a cursor read and one execute step; a refused send adds a refusal
// result; a star clear writes one cell per step from the cursor down to 0;
// a menu-held send emits 15 cells, each one read and then emitted, since
// the message memory has one registered read port.
// Every result waits additionally for the output register to drain.
module multi_tap_text_entry (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_key_code,
    input  logic       i_pressed,
    input  logic       i_held,
    input  logic       i_tx_allowed,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_event_res,
    output logic [3:0] o_position,
    output logic [6:0] o_character,
    output logic       o_last
);
    import mte_pkg::*;

    t_cmd    cmd;
    t_status st;

    mte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    mte_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_key_code   (i_key_code),
        .i_pressed    (i_pressed),
        .i_held       (i_held),
        .i_tx_allowed (i_tx_allowed),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_res  (o_event_res),
        .o_position   (o_position),
        .o_character  (o_character),
        .o_last       (o_last)
    );

endmodule

/* hdl/mte_dp.sv */
`timescale 1ns / 1ps

module mte_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mte_pkg::t_cmd   i_cmd,
    output mte_pkg::t_status o_st,
    input  logic [3:0]      i_key_code,
    input  logic            i_pressed,
    input  logic            i_held,
    input  logic            i_tx_allowed,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [2:0]      o_event_res,
    output logic [3:0]      o_position,
    output logic [6:0]      o_character,
    output logic            o_last
);
    import mte_pkg::*;

    // Latched request
    logic [3:0]         r_key, n_key;
    logic               r_pressed, n_pressed;
    logic               r_held, n_held;
    logic               r_tx, n_tx;

    // Editing state
    logic [PW-1:0]      r_cursor, n_cursor;
    logic [3:0]         r_last_key, n_last_key;
    logic               r_lkv, n_lkv;
    logic [4:0]         r_tap, n_tap;
    logic [MSG_LEN-1:0] r_cell_valid, n_cell_valid;
    logic [PW-1:0]      r_idx, n_idx;
    logic               r_ended, n_ended;

    // Message memory and its registered read port
    logic [6:0]         mem [MSG_LEN];
    logic [6:0]         r_rd_data;
    logic               r_rd_valid;
    logic               r_rd_zero;
    logic [PW-1:0]      rd_addr;
    logic [6:0]         rd_char;
    logic               mem_we;
    logic [6:0]         mem_wdata;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_ev, n_ev;
    logic [3:0]         r_pos, n_pos;
    logic [6:0]         r_ch, n_ch;
    logic               r_last, n_last;

    logic               emit;
    logic [2:0]         kind;
    logic               same_key;
    logic [4:0]         tap_inc;
    logic [4:0]         tap_next;
    logic [6:0]         dig_char;
    logic               can_adv;
    logic               filled;
    logic [PW-1:0]      adv_cursor;
    logic               ended_now;
    logic               send_last;

    // Request decode
    always_comb begin
        kind = K_NONE;
        if (r_pressed) begin
            if (r_key <= KEY_DIG9) begin
                kind = r_held ? K_NONE : K_DIGIT;
            end else if (r_key == KC_EXIT) begin
                kind = r_held ? K_EXIT_HELD : K_EXIT;
            end else if (r_key == KC_STAR) begin
                kind = r_held ? K_NONE : K_STAR;
            end else if (r_key == KC_MENU) begin
                if (!r_held) begin
                    kind = K_MENU;
                end else begin
                    kind = r_tx ? K_MENU_SEND : K_MENU_REFUSE;
                end
            end
        end
    end

    // Unwritten cells read as their reset value
    assign rd_char = r_rd_valid ? r_rd_data : (r_rd_zero ? CH_SPACE : CH_EMPTY);
    assign rd_addr = i_cmd.send_rd ? r_idx : r_cursor;

    // Multi-tap selection
    assign same_key   = r_lkv && (r_last_key == r_key);
    assign tap_inc    = r_tap + 5'd1;
    assign tap_next   = (same_key && (tap_inc < tap_len(r_key))) ? tap_inc : 5'd0;
    assign dig_char   = tap_char(r_key, tap_next);

    // Menu advance
    assign can_adv    = (r_cursor != PW'(LAST_POS));
    assign filled     = can_adv && (rd_char == CH_EMPTY);
    assign adv_cursor = can_adv ? r_cursor + PW'(1) : r_cursor;

    assign ended_now  = r_ended || (rd_char == CH_EMPTY);
    assign send_last  = (r_idx == PW'(SEND_END));

    assign o_st.kind        = kind;
    assign o_st.out_free    = !r_out_valid || !i_out_stall;
    assign o_st.cursor_zero = (r_cursor == '0);
    assign o_st.send_last   = send_last;

    // Next-state logic for the control, payload and output registers
    always_comb begin
        n_key        = r_key;
        n_pressed    = r_pressed;
        n_held       = r_held;
        n_tx         = r_tx;
        n_cursor     = r_cursor;
        n_last_key   = r_last_key;
        n_lkv        = r_lkv;
        n_tap        = r_tap;
        n_cell_valid = r_cell_valid;
        n_idx        = r_idx;
        n_ended      = r_ended;
        mem_we       = 1'b0;
        mem_wdata    = CH_SPACE;
        emit         = 1'b0;
        n_ev         = r_ev;
        n_pos        = r_pos;
        n_ch         = r_ch;
        n_last       = r_last;

        if (i_cmd.load_in) begin
            n_key     = i_key_code;
            n_pressed = i_pressed;
            n_held    = i_held;
            n_tx      = i_tx_allowed;
        end

        if (i_cmd.exec) begin
            case (kind)
                K_NONE: begin
                    emit = 1'b1; n_ev = EV_NONE; n_pos = r_cursor;
                    n_ch = CH_EMPTY; n_last = 1'b1;
                end
                K_DIGIT: begin
                    n_last_key = r_key;
                    n_lkv      = 1'b1;
                    n_tap      = tap_next;
                    mem_we     = 1'b1;
                    mem_wdata  = dig_char;
                    emit = 1'b1; n_ev = EV_WRITE; n_pos = r_cursor;
                    n_ch = dig_char; n_last = 1'b1;
                end
                K_EXIT: begin
                    n_lkv  = 1'b0;
                    mem_we = 1'b1;
                    emit = 1'b1; n_ev = EV_WRITE; n_pos = r_cursor;
                    n_ch = CH_SPACE; n_last = 1'b1;
                    if (r_cursor != '0) begin
                        n_cursor = r_cursor - PW'(1);
                    end
                end
                K_EXIT_HELD: begin
                    emit = 1'b1; n_ev = EV_EXIT; n_pos = r_cursor;
                    n_ch = CH_EMPTY; n_last = 1'b1;
                end
                K_MENU, K_MENU_SEND, K_MENU_REFUSE: begin
                    n_cursor = adv_cursor;
                    if (can_adv) begin
                        n_lkv = 1'b0;
                    end
                    if (filled) begin
                        mem_we = 1'b1;
                        emit = 1'b1; n_ev = EV_WRITE; n_pos = r_cursor;
                        n_ch = CH_SPACE; n_last = (kind == K_MENU);
                    end else if (kind == K_MENU) begin
                        emit = 1'b1; n_ev = EV_NONE; n_pos = adv_cursor;
                        n_ch = CH_EMPTY; n_last = 1'b1;
                    end
                    if (kind == K_MENU_SEND) begin
                        n_idx   = '0;
                        n_ended = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        // Star clear, one cell per step walking down
        if (i_cmd.star_step) begin
            n_lkv  = 1'b0;
            mem_we = 1'b1;
            emit = 1'b1; n_ev = EV_WRITE; n_pos = r_cursor;
            n_ch = CH_SPACE; n_last = (r_cursor == '0);
            if (r_cursor != '0) begin
                n_cursor = r_cursor - PW'(1);
            end
        end

        if (i_cmd.refuse_emit) begin
            emit = 1'b1; n_ev = EV_REFUSED; n_pos = r_cursor;
            n_ch = CH_EMPTY; n_last = 1'b1;
        end

        // Send run, everything after the first empty cell goes out as zero
        if (i_cmd.send_emit) begin
            emit = 1'b1; n_ev = EV_SEND; n_pos = r_idx;
            n_ch = ended_now ? CH_EMPTY : rd_char; n_last = send_last;
            n_ended = ended_now;
            n_idx   = r_idx + PW'(1);
        end

        if (mem_we) begin
            n_cell_valid[r_cursor] = 1'b1;
        end

        // Buffer back to reset contents after the run
        if (i_cmd.send_emit && send_last) begin
            n_cursor     = '0;
            n_cell_valid = '0;
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor     <= '0;
            r_last_key   <= '0;
            r_lkv        <= 1'b0;
            r_tap        <= '0;
            r_cell_valid <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_ended      <= 1'b0;
        end else begin
            r_cursor     <= n_cursor;
            r_last_key   <= n_last_key;
            r_lkv        <= n_lkv;
            r_tap        <= n_tap;
            r_cell_valid <= n_cell_valid;
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
            r_ended      <= n_ended;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_pressed <= n_pressed;
        r_held    <= n_held;
        r_tx      <= n_tx;
        r_ev      <= n_ev;
        r_pos     <= n_pos;
        r_ch      <= n_ch;
        r_last    <= n_last;
    end

    // Message memory write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cursor] <= mem_wdata;
        end
    end

    // Message memory read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cursor || i_cmd.send_rd) begin
            r_rd_data  <= mem[rd_addr];
            r_rd_valid <= r_cell_valid[rd_addr];
            r_rd_zero  <= (rd_addr == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_ev;
    assign o_position  = r_pos;
    assign o_character = r_ch;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !emit)
        else $error("result register overwritten while stalled");

    a_send_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.send_emit && send_last) |=> (r_cursor == '0 && r_cell_valid == '0))
        else $error("buffer not reset after send run");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_cursor || i_cmd.send_rd) |-> !mem_we)
        else $error("memory read and write in the same cycle");
`endif

endmodule

/* hdl/mte_ctrl.sv */
`timescale 1ns / 1ps

module mte_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mte_pkg::t_status i_st,
    output mte_pkg::t_cmd    o_cmd
);
    import mte_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RD      = 3'd1;
    localparam logic [2:0] S_EXEC    = 3'd2;
    localparam logic [2:0] S_STAR    = 3'd3;
    localparam logic [2:0] S_REFUSE  = 3'd4;
    localparam logic [2:0] S_SEND_RD = 3'd5;
    localparam logic [2:0] S_SEND_EM = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    // Sequencing of one request
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_cursor = 1'b1;
                n_state         = S_EXEC;
            end
            S_EXEC: begin
                if (i_st.out_free) begin
                    o_cmd.exec = 1'b1;
                    case (i_st.kind)
                        K_STAR:        n_state = S_STAR;
                        K_MENU_SEND:   n_state = S_SEND_RD;
                        K_MENU_REFUSE: n_state = S_REFUSE;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_STAR: begin
                if (i_st.out_free) begin
                    o_cmd.star_step = 1'b1;
                    if (i_st.cursor_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REFUSE: begin
                if (i_st.out_free) begin
                    o_cmd.refuse_emit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SEND_RD: begin
                o_cmd.send_rd = 1'b1;
                n_state       = S_SEND_EM;
            end
            S_SEND_EM: begin
                if (i_st.out_free) begin
                    o_cmd.send_emit = 1'b1;
                    n_state = i_st.send_last ? S_IDLE : S_SEND_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_RD))
        else $error("accepted request did not start a read");

    a_star_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAR && i_st.out_free && i_st.cursor_zero) |=> (r_state == S_IDLE))
        else $error("star clear did not stop at position zero");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");
`endif

endmodule
